### hw/rtl/pcgt_pkg.sv
//------------------------------------------------------------------------------
// pcgt_pkg
// Types and constants shared by the point cluster gated tracker.
//------------------------------------------------------------------------------
package pcgt_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned STEP_W  = 11;
    localparam int unsigned MISS_W  = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 2'd2;

    localparam logic [STEP_W-1:0] ZONE_STEP_RST  = 11'd20;
    localparam logic [STEP_W-1:0] JUMP_STEP_RST  = 11'd50;
    localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 8'd3;
    localparam logic [MISS_W-1:0] MISS_MAX       = 8'd255;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [MISS_W-1:0]  misses;
        logic               overflowed;
    } t_out_item;

    // Manhattan distance between two points, 11 bits
    function automatic logic [STEP_W-1:0] manh(
        input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
        input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by);
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return {1'b0, dx} + {1'b0, dy};
    endfunction

endpackage

### hw/rtl/point_cluster_gated_tracker.sv
//------------------------------------------------------------------------------
// point_cluster_gated_tracker
// Clusters the points of a frame into zones held in memories and tracks the
// largest zone from frame to frame.
//------------------------------------------------------------------------------
// Flow: a point reads and compares each open zone in turn, joins the first
// within the zone step or opens a new zone, then writes it. A frame end adds
// the largest-zone scan and gate, plus a nearest-point scan over the stored
// points when a track exists and the zone is accepted, then one result beat.
// Throughput: one point at a time, taken only in idle with no result pending.
// Reset: synchronous, active low; clears control and tracking state, the
// registers load their defaults and miss count starts saturated at 255.
//------------------------------------------------------------------------------
module point_cluster_gated_tracker #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pcgt_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pcgt_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcgt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcgt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned CW_Z = 2 * pcgt_pkg::COORD_W + 1;
    localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ZRD   = 10'b0000000010,
        S_ZCMP  = 10'b0000000100,
        S_ZWR   = 10'b0000001000,
        S_BRD   = 10'b0000010000,
        S_BCMP  = 10'b0000100000,
        S_FRD   = 10'b0001000000,
        S_GATE  = 10'b0010000000,
        S_NRD   = 10'b0100000000,
        S_NCMP  = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [pcgt_pkg::STEP_W-1:0] r_zone_step, r_jump_step;
    logic [pcgt_pkg::MISS_W-1:0] r_miss_limit, r_miss;
    logic [pcgt_pkg::COORD_W-1:0] r_px, r_py, r_tx, r_ty, r_bx, r_by;
    logic r_end, r_ovf, r_tvalid, r_found;
    logic [CW-1:0] r_ptot, r_ztot, r_idx, r_zsel, r_best, r_best_n;
    logic [CW_Z-1:0] r_bd;
    logic r_new;
    logic r_out_valid;
    pcgt_pkg::t_out_item r_out;

    // zone and stored-point memories
    logic z_we;
    logic [AW-1:0] z_waddr, z_raddr, s_raddr;
    logic [pcgt_pkg::COORD_W-1:0] zlx, zly, zfx, zfy, sx, sy;
    logic [CW-1:0] zcnt, zcnt_w;
    logic [AW-1:0] szone;
    logic zf_we, s_we;

    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(pcgt_pkg::COORD_W)) u_zlx (
        .i_clk, .i_we(z_we), .i_waddr(z_waddr), .i_wdata(r_px),
        .i_raddr(z_raddr), .o_rdata(zlx));
    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(pcgt_pkg::COORD_W)) u_zly (
        .i_clk, .i_we(z_we), .i_waddr(z_waddr), .i_wdata(r_py),
        .i_raddr(z_raddr), .o_rdata(zly));
    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(pcgt_pkg::COORD_W)) u_zfx (
        .i_clk, .i_we(zf_we), .i_waddr(z_waddr), .i_wdata(r_px),
        .i_raddr(z_raddr), .o_rdata(zfx));
    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(pcgt_pkg::COORD_W)) u_zfy (
        .i_clk, .i_we(zf_we), .i_waddr(z_waddr), .i_wdata(r_py),
        .i_raddr(z_raddr), .o_rdata(zfy));
    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(CW)) u_zcnt (
        .i_clk, .i_we(z_we), .i_waddr(z_waddr), .i_wdata(zcnt_w),
        .i_raddr(z_raddr), .o_rdata(zcnt));
    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(pcgt_pkg::COORD_W)) u_sx (
        .i_clk, .i_we(s_we), .i_waddr(r_ptot[AW-1:0]), .i_wdata(r_px),
        .i_raddr(s_raddr), .o_rdata(sx));
    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(pcgt_pkg::COORD_W)) u_sy (
        .i_clk, .i_we(s_we), .i_waddr(r_ptot[AW-1:0]), .i_wdata(r_py),
        .i_raddr(s_raddr), .o_rdata(sy));
    pcgt_ram #(.DEPTH(MAX_POINTS), .WIDTH(AW)) u_sz (
        .i_clk, .i_we(s_we), .i_waddr(r_ptot[AW-1:0]), .i_wdata(r_zsel[AW-1:0]),
        .i_raddr(s_raddr), .o_rdata(szone));

    // S_ZCMP reads zone r_idx; S_ZWR writes zone r_zsel with its count read back
    assign z_raddr = r_idx[AW-1:0];
    assign s_raddr = r_idx[AW-1:0];
    assign z_waddr = r_zsel[AW-1:0];
    assign z_we    = (r_state == S_ZWR);
    assign zf_we   = z_we && r_new;
    assign s_we    = z_we;
    assign zcnt_w  = r_new ? CW'(1) : zcnt + CW'(1);

    logic in_acc, cfg_acc;
    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic [pcgt_pkg::STEP_W-1:0] d_join, d_jump;
    assign d_join = pcgt_pkg::manh(zlx, zly, r_px, r_py);
    assign d_jump = pcgt_pkg::manh(zfx, zfy, r_tx, r_ty);

    logic [pcgt_pkg::COORD_W-1:0] ddx, ddy;
    logic [2*pcgt_pkg::COORD_W-1:0] sqx, sqy;
    logic [CW_Z-1:0] dsq;
    assign ddx = (r_tx > sx) ? r_tx - sx : sx - r_tx;
    assign ddy = (r_ty > sy) ? r_ty - sy : sy - r_ty;
    assign sqx = {{pcgt_pkg::COORD_W{1'b0}}, ddx} * {{pcgt_pkg::COORD_W{1'b0}}, ddx};
    assign sqy = {{pcgt_pkg::COORD_W{1'b0}}, ddy} * {{pcgt_pkg::COORD_W{1'b0}}, ddy};
    assign dsq = {1'b0, sqx} + {1'b0, sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_step  <= pcgt_pkg::ZONE_STEP_RST;
            r_jump_step  <= pcgt_pkg::JUMP_STEP_RST;
            r_miss_limit <= pcgt_pkg::MISS_LIMIT_RST;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                pcgt_pkg::CFG_ZONE_STEP:  r_zone_step  <= i_cfg_data;
                pcgt_pkg::CFG_JUMP_STEP:  r_jump_step  <= i_cfg_data;
                pcgt_pkg::CFG_MISS_LIMIT: r_miss_limit <= i_cfg_data[pcgt_pkg::MISS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptot      <= '0;
            r_ztot      <= '0;
            r_ovf       <= 1'b0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_tvalid    <= 1'b0;
            r_miss      <= pcgt_pkg::MISS_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_px  <= i_in_data.pos_x;
                        r_py  <= i_in_data.pos_y;
                        r_end <= i_in_data.frame_end;
                        r_idx <= '0;
                        if (r_ptot >= CAP) begin
                            r_ovf <= 1'b1;
                            r_best_n <= '0;
                            r_best   <= '0;
                            r_state  <= i_in_data.frame_end ? S_BRD : S_IDLE;
                        end else begin
                            r_state <= S_ZRD;
                        end
                    end
                end
                S_ZRD: begin
                    // address r_idx presented; data next cycle
                    if (r_idx >= r_ztot) begin
                        r_zsel  <= r_ztot;
                        r_new   <= 1'b1;
                        r_ztot  <= r_ztot + CW'(1);
                        r_state <= S_ZWR;
                    end else begin
                        r_state <= S_ZCMP;
                    end
                end
                S_ZCMP: begin
                    if (d_join <= r_zone_step) begin
                        r_zsel  <= r_idx;
                        r_new   <= 1'b0;
                        r_state <= S_ZWR;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_ZRD;
                    end
                end
                S_ZWR: begin
                    // count read of r_zsel is valid here (r_idx == r_zsel when joining)
                    r_ptot   <= r_ptot + CW'(1);
                    r_idx    <= '0;
                    r_best_n <= '0;
                    r_best   <= '0;
                    r_state  <= r_end ? S_BRD : S_IDLE;
                end
                S_BRD: begin
                    if (r_idx >= r_ztot) begin
                        r_idx   <= r_best;
                        r_state <= S_FRD;
                    end else begin
                        r_state <= S_BCMP;
                    end
                end
                S_BCMP: begin
                    if (zcnt > r_best_n) begin
                        r_best_n <= zcnt;
                        r_best   <= r_idx;
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_BRD;
                end
                S_FRD: begin
                    // zone r_best address presented; its first point arrives next cycle
                    r_state <= S_GATE;
                end
                S_GATE: begin
                    // zone r_best first point is on the read port now
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (r_best_n != '0) begin
                        if (r_miss >= r_miss_limit || d_jump <= r_jump_step) begin
                            r_miss <= '0;
                            if (!r_tvalid) begin
                                r_tx     <= zfx;
                                r_ty     <= zfy;
                                r_tvalid <= 1'b1;
                                r_out_valid <= 1'b1;
                                r_out <= '{1'b1, zfx, zfy, '0, r_ovf};
                                r_ptot <= '0;
                                r_ztot <= '0;
                                r_ovf  <= 1'b0;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_NRD;
                            end
                        end else begin
                            if (r_miss != pcgt_pkg::MISS_MAX) begin
                                r_miss <= r_miss + 8'd1;
                            end
                            r_out_valid <= 1'b1;
                            r_out <= '{1'b0, r_tx, r_ty,
                                (r_miss != pcgt_pkg::MISS_MAX) ? r_miss + 8'd1 : r_miss,
                                r_ovf};
                            r_ptot <= '0;
                            r_ztot <= '0;
                            r_ovf  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_out_valid <= 1'b1;
                        r_out  <= '{1'b0, r_tx, r_ty, r_miss, r_ovf};
                        r_ptot <= '0;
                        r_ztot <= '0;
                        r_ovf  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_NRD: begin
                    if (r_idx >= r_ptot) begin
                        r_tx <= r_bx;
                        r_ty <= r_by;
                        r_out_valid <= 1'b1;
                        r_out  <= '{1'b1, r_bx, r_by, r_miss, r_ovf};
                        r_ptot <= '0;
                        r_ztot <= '0;
                        r_ovf  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_NCMP;
                    end
                end
                S_NCMP: begin
                    if ({{(CW-AW){1'b0}}, szone} == r_best && (!r_found || dsq < r_bd)) begin
                        r_found <= 1'b1;
                        r_bd    <= dsq;
                        r_bx    <= sx;
                        r_by    <= sy;
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_NRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/pcgt_ram.sv
//------------------------------------------------------------------------------
// pcgt_ram
// Single-port-write, single-read synchronous memory with a registered read.
//------------------------------------------------------------------------------
module pcgt_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
